// ===== sv/pfr_pkg.sv =====
// shared definitions for the page frame buffer: request codes, panel command
// bytes, default geometry and the controller/datapath handshake structs
// no dependencies
`default_nettype none

package pfr_pkg;

   // request kinds carried in req_tuser
   localparam logic [1:0] REQ_SET_PIXEL = 2'd0;
   localparam logic [1:0] REQ_CLEAR     = 2'd1;
   localparam logic [1:0] REQ_REFRESH   = 2'd2;
   localparam logic [1:0] REQ_UNUSED    = 2'd3;

   // per-page command preamble on the refresh stream
   localparam logic [7:0] CMD_PAGE_ADDR = 8'h22;
   localparam logic [7:0] CMD_COL_LOW   = 8'h00;
   localparam logic [7:0] CMD_COL_HIGH  = 8'h10;
   localparam int         CMD_SLOTS     = 4;

   localparam int DEF_COLUMN_COUNT = 128;
   localparam int DEF_PAGE_COUNT   = 4;

   typedef struct packed {
      logic accept;   // latch the request and issue the store read
      logic sweep;    // write zero at the sweep address and step it
      logic commit;   // finish the request: write back, advance, load response
   } cmd_type;

   typedef struct packed {
      logic sweep_last;
   } status_type;

endpackage

`default_nettype wire

// ===== sv/pfr_ctrl.sv =====
// controller for the page frame buffer: sequences reset sweep, clear sweep,
// request acceptance and response hand-off
// depends on pfr_pkg
`default_nettype none

module pfr_ctrl
   import pfr_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [1:0] req_type,
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output cmd_type         cmd,
   input  wire status_type status
);

   localparam logic [1:0] ST_INIT   = 2'd0;
   localparam logic [1:0] ST_IDLE   = 2'd1;
   localparam logic [1:0] ST_CLEAR  = 2'd2;
   localparam logic [1:0] ST_FINISH = 2'd3;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_INIT: begin
            cmd.sweep = 1'b1;
            if (status.sweep_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               state_in   = (req_type == REQ_CLEAR) ? ST_CLEAR : ST_FINISH;
            end
         end
         ST_CLEAR: begin
            cmd.sweep = 1'b1;
            if (status.sweep_last) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_INIT;
         end
      endcase
   end

   assign rsp_valid_in = cmd.commit || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   // a clear request always goes through the sweep
   a_clear_sweeps: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_type == REQ_CLEAR) |=> state_ff == ST_CLEAR)
      else $error("clear request did not start the sweep");

   // a pending response is never overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> (!rsp_valid_ff || rsp_tready))
      else $error("response overwritten before it was taken");

   // nothing leaves the block during the power-on sweep
   a_init_quiet: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_INIT |-> !rsp_valid_ff && !req_tready)
      else $error("traffic during the reset sweep");

endmodule

`default_nettype wire

// ===== sv/pfr_datapath.sv =====
// datapath for the page frame buffer: frame store memory, sweep address,
// refresh position and the response registers
// depends on pfr_pkg
`default_nettype none

module pfr_datapath
   import pfr_pkg::*;
#(
   parameter int COLUMN_COUNT = DEF_COLUMN_COUNT,
   parameter int PAGE_COUNT   = DEF_PAGE_COUNT
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire cmd_type    cmd,
   output status_type      status,
   input  wire logic [1:0] req_type,
   input  wire logic [7:0] pixel_column,
   input  wire logic [5:0] pixel_row,
   input  wire logic       pixel_on,
   output logic [7:0]      stream_byte,
   output logic            is_data,
   output logic            frame_last,
   output logic            ignored
);

   localparam int DEPTH = COLUMN_COUNT * PAGE_COUNT;
   localparam int AW    = $clog2(DEPTH);
   localparam int SLOTS = CMD_SLOTS + COLUMN_COUNT;
   localparam int SW    = $clog2(SLOTS);
   localparam int PW    = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;

   logic [7:0]    frame_store_ff [DEPTH];
   logic [7:0]    rd_data_ff;
   logic [AW-1:0] clr_addr_ff;

   logic [1:0]    type_ff;
   logic [2:0]    bit_ff;
   logic          on_ff;
   logic          in_range_ff;
   logic [AW-1:0] wr_addr_ff;

   logic [PW-1:0] page_ff, page_in;
   logic [SW-1:0] slot_ff, slot_in;

   logic [7:0]    stream_ff, stream_in;
   logic          is_data_ff, is_data_in;
   logic          last_ff, last_in;
   logic          ign_ff, ign_in;

   logic          in_range;
   logic [AW-1:0] pix_addr, ref_addr, rd_addr;
   logic          ref_is_data;
   logic [7:0]    ref_byte, bit_mask, merged;
   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   logic [7:0]    mem_wdata;

   // bounds and store address of the incoming pixel
   assign in_range = ({1'b0, pixel_column} < 9'(COLUMN_COUNT))
                  && ({1'b0, pixel_row} < 7'(8 * PAGE_COUNT));
   assign pix_addr = in_range
      ? AW'(int'(pixel_row[5:3]) * COLUMN_COUNT + int'(pixel_column)) : '0;

   // data slots start after the command preamble
   assign ref_is_data = (slot_ff >= SW'(CMD_SLOTS));
   assign ref_addr    = ref_is_data
      ? AW'(int'(page_ff) * COLUMN_COUNT + int'(slot_ff) - CMD_SLOTS) : '0;

   assign rd_addr = (req_type == REQ_SET_PIXEL) ? pix_addr : ref_addr;

   always_comb begin
      if (slot_ff == SW'(0)) begin
         ref_byte = CMD_PAGE_ADDR;
      end else if (slot_ff == SW'(1)) begin
         ref_byte = 8'(page_ff);
      end else if (slot_ff == SW'(2)) begin
         ref_byte = CMD_COL_LOW;
      end else if (slot_ff == SW'(3)) begin
         ref_byte = CMD_COL_HIGH;
      end else begin
         ref_byte = rd_data_ff;
      end
   end

   // next refresh position, wrapping at the end of page and frame
   always_comb begin
      page_in = page_ff;
      slot_in = slot_ff;
      if (cmd.commit && type_ff == REQ_REFRESH) begin
         if (slot_ff == SW'(SLOTS - 1)) begin
            slot_in = '0;
            page_in = (page_ff == PW'(PAGE_COUNT - 1)) ? '0 : page_ff + PW'(1);
         end else begin
            slot_in = slot_ff + SW'(1);
         end
      end
   end

   assign bit_mask = 8'd1 << bit_ff;
   assign merged   = (rd_data_ff & ~bit_mask) | (on_ff ? bit_mask : 8'd0);

   assign mem_we    = cmd.sweep
                   || (cmd.commit && type_ff == REQ_SET_PIXEL && in_range_ff);
   assign mem_waddr = cmd.sweep ? clr_addr_ff : wr_addr_ff;
   assign mem_wdata = cmd.sweep ? 8'd0 : merged;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         frame_store_ff[mem_waddr] <= mem_wdata;
      end
      if (cmd.accept) begin
         rd_data_ff <= frame_store_ff[rd_addr];
      end
   end

   assign status.sweep_last = (clr_addr_ff == AW'(DEPTH - 1));

   always_comb begin
      stream_in  = 8'd0;
      is_data_in = 1'b0;
      last_in    = 1'b0;
      ign_in     = 1'b0;
      case (type_ff)
         REQ_SET_PIXEL: begin
            ign_in = !in_range_ff;
         end
         REQ_REFRESH: begin
            stream_in  = ref_byte;
            is_data_in = ref_is_data;
            last_in    = ref_is_data && (page_ff == PW'(PAGE_COUNT - 1))
                      && (slot_ff == SW'(SLOTS - 1));
         end
         default: begin
            ign_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
         page_ff     <= '0;
         slot_ff     <= '0;
      end else begin
         if (cmd.sweep) begin
            clr_addr_ff <= status.sweep_last ? '0 : clr_addr_ff + AW'(1);
         end
         page_ff <= page_in;
         slot_ff <= slot_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         type_ff     <= req_type;
         bit_ff      <= pixel_row[2:0];
         on_ff       <= pixel_on;
         in_range_ff <= in_range;
         wr_addr_ff  <= pix_addr;
      end
      if (cmd.commit) begin
         stream_ff  <= stream_in;
         is_data_ff <= is_data_in;
         last_ff    <= last_in;
         ign_ff     <= ign_in;
      end
   end

   assign stream_byte = stream_ff;
   assign is_data     = is_data_ff;
   assign frame_last  = last_ff;
   assign ignored     = ign_ff;

endmodule

`default_nettype wire

// ===== sv/page_framebuffer_refresh.sv =====
// Page-organised monochrome frame store with a byte-per-request refresh
// stream. After reset the store is zeroed by a sweep over all COLUMN_COUNT *
// PAGE_COUNT bytes (512 at the defaults) during which no request is taken.
// A set-pixel, refresh-step or unused request has an accept step, which issues
// the registered read of the single-port store, and a finish step, taken once
// the output register is free, that writes the modified byte back for a
// set-pixel and loads the response register. A clear request sweeps zeros
// over the store one byte per cycle before its finish step. A new request is
// accepted while the previous response still waits in the output register.
// top level; depends on pfr_pkg, pfr_ctrl and pfr_datapath
`default_nettype none

module page_framebuffer_refresh
   import pfr_pkg::*;
#(
   parameter int COLUMN_COUNT = DEF_COLUMN_COUNT,
   parameter int PAGE_COUNT   = DEF_PAGE_COUNT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,   // pixel_column[7:0], pixel_row[13:8], pixel_on[14]
   input  wire logic [1:0]  req_tuser,   // req_type[1:0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,   // stream_byte[7:0], ignored[8]
   output logic [0:0]       rsp_tuser,   // is_data[0]
   output logic             rsp_tlast    // frame_last
);

   cmd_type    cmd;
   status_type status;
   logic [7:0] stream_byte;
   logic       is_data;
   logic       ignored;

   pfr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_type   (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .status     (status)
   );

   pfr_datapath #(
      .COLUMN_COUNT (COLUMN_COUNT),
      .PAGE_COUNT   (PAGE_COUNT)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .req_type     (req_tuser),
      .pixel_column (req_tdata[7:0]),
      .pixel_row    (req_tdata[13:8]),
      .pixel_on     (req_tdata[14]),
      .stream_byte  (stream_byte),
      .is_data      (is_data),
      .frame_last   (rsp_tlast),
      .ignored      (ignored)
   );

   assign rsp_tdata = {7'd0, ignored, stream_byte};
   assign rsp_tuser = is_data;

endmodule

`default_nettype wire
